// ----- hdl/bse_pkg.sv -----
// shared types and constants for the button scroll emulator
`default_nettype none

package bse_pkg;

  localparam int unsigned KIND_BITS = 3;
  localparam int unsigned THR_BITS  = 10;
  localparam int unsigned ACC_BITS  = 18;

  localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(10);

  typedef enum logic [KIND_BITS-1:0] {
    EV_MOVE  = 3'd0,
    EV_XDOWN = 3'd1,
    EV_XUP   = 3'd2,
    EV_LDOWN = 3'd3,
    EV_LUP   = 3'd4,
    EV_RDOWN = 3'd5,
    EV_RUP   = 3'd6,
    EV_OTHER = 3'd7
  } event_kind_e;

endpackage

`default_nettype wire

// ----- hdl/bse_if.sv -----
// channel interfaces: pointer events in, results out, threshold writes
`default_nettype none

interface bse_in_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                                   valid;
  logic                                   ready;
  logic        [bse_pkg::KIND_BITS-1:0]   event_kind;
  logic signed [COORD_BITS-1:0]           pos_x;
  logic signed [COORD_BITS-1:0]           pos_y;

  modport source (output valid, event_kind, pos_x, pos_y, input ready);
  modport sink   (input valid, event_kind, pos_x, pos_y, output ready);
endinterface

interface bse_out_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         forward_event;
  logic                         warp_valid;
  logic signed [COORD_BITS-1:0] warp_x;
  logic signed [COORD_BITS-1:0] warp_y;
  logic                         wheel_valid;
  logic                         wheel_up;
  logic signed [COORD_BITS-1:0] wheel_x;
  logic signed [COORD_BITS-1:0] wheel_y;

  modport source (output valid, forward_event, warp_valid, warp_x, warp_y,
                  wheel_valid, wheel_up, wheel_x, wheel_y, input ready);
  modport sink   (input valid, forward_event, warp_valid, warp_x, warp_y,
                  wheel_valid, wheel_up, wheel_x, wheel_y, output ready);
endinterface

interface bse_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bse_pkg::THR_BITS-1:0]    data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/button_scroll_emulator_core.sv -----
// button scroll emulator: mode machine, origin latch, accumulator, notch output
//
//  channel   dir  handshake      payload
//  evt_i     in   valid/ready    event_kind, pos_x, pos_y
//  res_o     out  valid/ready    forward_event, warp_*, wheel_valid, wheel_up, wheel_*
//  cfg_i     in   valid/ready    data = scroll_threshold (always ready)
//
//  event beat to result beat passes the input register, then the result register
//  one event per cycle sustained unless res_o stalls; mode, origin and accumulator
//  update as the event moves from the input register into the result register
//  a stalled result holds the input register, which then drops evt_i.ready
//  reset clears mode, origin, accumulator and sets the threshold to ten
`default_nettype none

module button_scroll_emulator_core #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  bse_in_if.sink        evt_i,
  bse_out_if.source     res_o,
  bse_cfg_if.sink       cfg_i
);

  localparam int unsigned SUM_BITS =
    (COORD_BITS + 2 > bse_pkg::ACC_BITS + 1) ? COORD_BITS + 2 : bse_pkg::ACC_BITS + 1;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_XDOWN    = 3'd1,
    MODE_XSCROLL  = 3'd2,
    MODE_LDOWN    = 3'd3,
    MODE_RDOWN    = 3'd4,
    MODE_LRDOWN   = 3'd5,
    MODE_LRSCROLL = 3'd6
  } mode_e;

  // threshold register
  logic [bse_pkg::THR_BITS-1:0] thr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= bse_pkg::THR_RESET;
    end else if (cfg_i.valid) begin
      thr_q <= cfg_i.data;
    end
  end

  // input register
  logic                            s1_valid_q;
  logic [bse_pkg::KIND_BITS-1:0]   s1_kind_q;
  logic signed [COORD_BITS-1:0]    s1_x_q;
  logic signed [COORD_BITS-1:0]    s1_y_q;
  logic                            advance;
  logic                            in_fire;

  assign advance     = s1_valid_q && (!res_o.valid || res_o.ready);
  assign evt_i.ready = !s1_valid_q || advance;
  assign in_fire     = evt_i.valid && evt_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      s1_valid_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q <= evt_i.event_kind;
      s1_x_q    <= evt_i.pos_x;
      s1_y_q    <= evt_i.pos_y;
    end
  end

  // state and decision logic
  mode_e                              mode_q, mode_d;
  logic signed [COORD_BITS-1:0]       origin_x_q, origin_y_q;
  logic signed [bse_pkg::ACC_BITS-1:0] accum_q, accum_d;
  logic                               fwd, warp, accumulate, latch, clear_acc;
  logic                               wheel, wheel_up;
  logic signed [SUM_BITS-1:0]         sum, thr_ext;

  assign thr_ext = SUM_BITS'(signed'({1'b0, thr_q}));
  assign sum     = SUM_BITS'(accum_q) + SUM_BITS'(s1_y_q) - SUM_BITS'(origin_y_q);

  always_comb begin
    mode_d     = mode_q;
    fwd        = 1'b1;
    warp       = 1'b0;
    accumulate = 1'b0;
    latch      = 1'b0;
    clear_acc  = 1'b0;
    unique case (mode_q)
      MODE_IDLE: begin
        if (s1_kind_q == bse_pkg::EV_XDOWN) begin
          fwd    = 1'b0;
          mode_d = MODE_XDOWN;
          latch  = 1'b1;
        end else if (s1_kind_q == bse_pkg::EV_LDOWN) begin
          mode_d = MODE_LDOWN;
          latch  = 1'b1;
        end
      end
      MODE_XDOWN: begin
        if (s1_kind_q == bse_pkg::EV_MOVE) begin
          fwd       = 1'b0;
          mode_d    = MODE_XSCROLL;
          clear_acc = 1'b1;
          warp      = 1'b1;
        end
      end
      MODE_XSCROLL: begin
        if (s1_kind_q == bse_pkg::EV_XUP) begin
          fwd    = 1'b0;
          mode_d = MODE_IDLE;
        end else if (s1_kind_q == bse_pkg::EV_MOVE) begin
          accumulate = 1'b1;
        end
      end
      MODE_LDOWN: begin
        if (s1_kind_q == bse_pkg::EV_RDOWN) begin
          fwd    = 1'b0;
          mode_d = MODE_LRDOWN;
          latch  = 1'b1;
        end else if (s1_kind_q == bse_pkg::EV_LUP) begin
          mode_d = MODE_IDLE;
        end
      end
      MODE_LRDOWN: begin
        if (s1_kind_q == bse_pkg::EV_MOVE) begin
          fwd       = 1'b0;
          mode_d    = MODE_LRSCROLL;
          clear_acc = 1'b1;
          warp      = 1'b1;
        end else if (s1_kind_q == bse_pkg::EV_LUP) begin
          mode_d = MODE_IDLE;
        end else if (s1_kind_q == bse_pkg::EV_RUP) begin
          fwd    = 1'b0;
          mode_d = MODE_LDOWN;
        end
      end
      MODE_LRSCROLL: begin
        if (s1_kind_q == bse_pkg::EV_LUP) begin
          fwd    = 1'b0;
          mode_d = MODE_IDLE;
        end else if (s1_kind_q == bse_pkg::EV_RUP) begin
          fwd    = 1'b0;
          mode_d = MODE_LDOWN;
        end else if (s1_kind_q == bse_pkg::EV_MOVE) begin
          accumulate = 1'b1;
        end
      end
      MODE_RDOWN: begin
        // unreachable holding mode: everything forwarded
      end
      default: begin
      end
    endcase

    wheel    = 1'b0;
    wheel_up = 1'b0;
    accum_d  = accum_q;
    if (clear_acc) begin
      accum_d = '0;
    end
    if (accumulate) begin
      fwd  = 1'b0;
      warp = 1'b1;
      if (sum < -thr_ext || sum > thr_ext) begin
        wheel    = 1'b1;
        wheel_up = sum[SUM_BITS-1];
        accum_d  = '0;
      end else begin
        // within the threshold, so the kept value fits the accumulator
        accum_d = bse_pkg::ACC_BITS'(sum);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      origin_x_q <= '0;
      origin_y_q <= '0;
      accum_q    <= '0;
    end else if (advance) begin
      mode_q  <= mode_d;
      accum_q <= accum_d;
      if (latch) begin
        origin_x_q <= s1_x_q;
        origin_y_q <= s1_y_q;
      end
    end
  end

  // result register
  logic                         out_valid_q;
  logic                         fwd_q, warp_q, wheel_q, up_q;
  logic signed [COORD_BITS-1:0] warp_x_q, warp_y_q, wheel_x_q, wheel_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      fwd_q     <= fwd;
      warp_q    <= warp;
      warp_x_q  <= warp ? origin_x_q : '0;
      warp_y_q  <= warp ? origin_y_q : '0;
      wheel_q   <= wheel;
      up_q      <= wheel && wheel_up;
      wheel_x_q <= wheel ? s1_x_q : '0;
      wheel_y_q <= wheel ? s1_y_q : '0;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.forward_event = fwd_q;
  assign res_o.warp_valid    = warp_q;
  assign res_o.warp_x        = warp_x_q;
  assign res_o.warp_y        = warp_y_q;
  assign res_o.wheel_valid   = wheel_q;
  assign res_o.wheel_up      = up_q;
  assign res_o.wheel_x       = wheel_x_q;
  assign res_o.wheel_y       = wheel_y_q;

  // checks
  a_notch_needs_warp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.wheel_valid |-> res_o.warp_valid && !res_o.forward_event)
    else $error("wheel notch without warp or with forward");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && res_o.valid && !res_o.ready |-> !evt_i.ready)
    else $error("input taken while result stalled and input register full");

  a_advance_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> res_o.valid)
    else $error("processed beat lost from result register");

  a_no_rdown_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != MODE_RDOWN)
    else $error("right down mode entered");

endmodule

`default_nettype wire
